/* hdl/lre_pkg.sv */
// ----------------------------------------------------------------------------
// lre_pkg
// Shared types, constants and helpers of the left-to-right expression
// evaluator: operator codes, queue entry layout, divider handshake.
// ----------------------------------------------------------------------------
package lre_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(DATA_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int OUT_W       = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NOP
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_t;

  // One closed number and what to do with it.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] num;
    op_t                   op;
    logic                  last;
  } q_entry_t;

  typedef struct packed {
    logic                  start;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quotient;
  } div_rsp_t;

  function automatic op_t classify(input logic [7:0] ch);
    op_t op;
    begin
      priority if (ch == CH_PLUS)  op = OP_ADD;
      else if (ch == CH_MINUS)     op = OP_SUB;
      else if (ch == CH_STAR)      op = OP_MUL;
      else if (ch == CH_SLASH)     op = OP_DIV;
      else                         op = OP_NOP;
      return op;
    end
  endfunction

  // Sign-extend or truncate the accumulator to the result width.
  function automatic logic [OUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] s;
    begin
      s = signed'(v);
      return OUT_W'(s);
    end
  endfunction

endpackage

/* hdl/lre_front.sv */
// ----------------------------------------------------------------------------
// lre_front
// Accepts characters, builds the current number from digits and pushes one
// queue entry for each closed number, tagged with the operator to apply.
// ----------------------------------------------------------------------------
module lre_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_last,
  input  logic               q_full,
  output logic               q_push,
  output lre_pkg::q_entry_t  q_entry
);

  logic [lre_pkg::DATA_WIDTH-1:0] cur_r, cur_nxt;
  lre_pkg::op_t                   pend_r, pend_nxt;
  logic                           seen_r, seen_nxt;
  logic                           second_r, second_nxt;

  logic                           accept;
  logic                           is_digit;
  logic [3:0]                     digit;
  logic [7:0]                     digit_full;
  logic [lre_pkg::DATA_WIDTH-1:0] num_ext;
  lre_pkg::op_t                   close_op;

  always_comb begin
    in_ready   = !second_r && !q_full;
    accept     = in_valid && in_ready;
    is_digit   = (in_char_code >= lre_pkg::CH_ZERO) && (in_char_code <= lre_pkg::CH_NINE);
    digit_full = in_char_code - lre_pkg::CH_ZERO;
    digit      = digit_full[3:0];
    num_ext    = (cur_r << 3) + (cur_r << 1) + lre_pkg::DATA_WIDTH'(digit);
    close_op   = seen_r ? pend_r : lre_pkg::OP_LOAD;

    cur_nxt    = cur_r;
    pend_nxt   = pend_r;
    seen_nxt   = seen_r;
    second_nxt = second_r;
    q_push     = 1'b0;
    q_entry.num  = cur_r;
    q_entry.op   = close_op;
    q_entry.last = 1'b0;

    if (second_r) begin
      // trailing operator on the last character: close an empty number
      q_entry.num  = '0;
      q_entry.op   = pend_r;
      q_entry.last = 1'b1;
      if (!q_full) begin
        q_push     = 1'b1;
        second_nxt = 1'b0;
        pend_nxt   = lre_pkg::OP_NOP;
        seen_nxt   = 1'b0;
      end
    end else if (accept) begin
      if (is_digit) begin
        if (in_is_last) begin
          q_push       = 1'b1;
          q_entry.num  = num_ext;
          q_entry.last = 1'b1;
          cur_nxt      = '0;
          seen_nxt     = 1'b0;
          pend_nxt     = lre_pkg::OP_NOP;
        end else begin
          cur_nxt = num_ext;
        end
      end else begin
        q_push     = 1'b1;
        cur_nxt    = '0;
        seen_nxt   = 1'b1;
        pend_nxt   = lre_pkg::classify(in_char_code);
        second_nxt = in_is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      pend_r   <= lre_pkg::OP_NOP;
      seen_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      pend_r   <= pend_nxt;
      seen_r   <= seen_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* hdl/lre_queue.sv */
// ----------------------------------------------------------------------------
// lre_queue
// Short first-in first-out queue of closed numbers between front and back.
// ----------------------------------------------------------------------------
module lre_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lre_pkg::q_entry_t push_entry,
  input  logic              pop,
  output lre_pkg::q_entry_t head,
  output logic              full,
  output logic              empty
);

  lre_pkg::q_entry_t               mem [lre_pkg::QUEUE_DEPTH];
  logic [lre_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lre_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lre_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == lre_pkg::QCNT_W'(lre_pkg::QUEUE_DEPTH));
    empty      = (cnt_r == '0);
    head       = mem[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + lre_pkg::QCNT_W'(push) - lre_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hdl/lre_divider.sv */
// ----------------------------------------------------------------------------
// lre_divider
// Signed truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lre_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  lre_pkg::div_req_t req,
  output lre_pkg::div_rsp_t rsp
);

  localparam int DW = lre_pkg::DATA_WIDTH;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lre_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]                 rem_r, rem_nxt;
  logic [DW-1:0]                 quo_r, quo_nxt;
  logic [DW-1:0]                 dsr_r, dsr_nxt;
  logic                          neg_r, neg_nxt;

  logic [DW:0]                   rem_sh;
  logic [DW+1:0]                 diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[DW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_r};

    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = lre_pkg::CNT_W'(DW - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend[DW-1] ? DW'(0) - req.dividend : req.dividend;
      dsr_nxt  = req.divisor[DW-1]  ? DW'(0) - req.divisor  : req.divisor;
      neg_nxt  = req.dividend[DW-1] ^ req.divisor[DW-1];
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (diff[DW+1]) begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end

    rsp.done     = done_r;
    rsp.quotient = neg_r ? DW'(0) - quo_r : quo_r;
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

/* hdl/lre_back.sv */
// ----------------------------------------------------------------------------
// lre_back
// Applies queued numbers to the accumulator, runs divisions on the bit-serial
// divider and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module lre_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lre_pkg::q_entry_t          head,
  input  logic                       q_empty,
  output logic                       q_pop,
  output lre_pkg::div_req_t          div_req,
  input  lre_pkg::div_rsp_t          div_rsp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lre_pkg::OUT_W-1:0]  out_value,
  output logic                       out_div_zero
);

  localparam int DW = lre_pkg::DATA_WIDTH;

  lre_pkg::back_state_t          state_r, state_nxt;
  logic [DW-1:0]                 acc_r, acc_nxt;
  logic                          err_r, err_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [lre_pkg::OUT_W-1:0]     out_value_r, out_value_nxt;
  logic                          out_dz_r, out_dz_nxt;

  logic                          out_free;
  logic                          can_go;
  logic                          finish;
  logic [DW-1:0]                 acc_new;
  logic                          err_new;
  logic [DW-1:0]                 prod;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    can_go   = !q_empty && (!head.last || out_free);
    prod     = acc_r * head.num;

    state_nxt     = state_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_dz_nxt    = out_dz_r;
    q_pop         = 1'b0;
    finish        = 1'b0;
    acc_new       = acc_r;
    err_new       = err_r;
    div_req.start    = 1'b0;
    div_req.dividend = acc_r;
    div_req.divisor  = head.num;

    unique case (state_r)
      lre_pkg::BK_IDLE: begin
        if (can_go) begin
          finish = 1'b1;
          unique case (head.op)
            lre_pkg::OP_LOAD: acc_new = head.num;
            lre_pkg::OP_ADD:  acc_new = acc_r + head.num;
            lre_pkg::OP_SUB:  acc_new = acc_r - head.num;
            lre_pkg::OP_MUL:  acc_new = prod;
            lre_pkg::OP_DIV: begin
              if (head.num == '0) begin
                err_new = 1'b1;
              end else begin
                // hold the entry until the quotient is ready
                finish        = 1'b0;
                div_req.start = 1'b1;
                state_nxt     = lre_pkg::BK_DIV;
              end
            end
            lre_pkg::OP_NOP:  acc_new = acc_r;
            default:          acc_new = acc_r;
          endcase
        end
      end
      lre_pkg::BK_DIV: begin
        if (div_rsp.done && can_go) begin
          finish    = 1'b1;
          acc_new   = div_rsp.quotient;
          state_nxt = lre_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lre_pkg::BK_IDLE;
    endcase

    if (finish) begin
      q_pop   = 1'b1;
      acc_nxt = acc_new;
      err_nxt = err_new;
      if (head.last) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = lre_pkg::to_out(acc_new);
        out_dz_nxt    = err_new;
        acc_nxt       = '0;
        err_nxt       = 1'b0;
      end
    end

    out_valid    = out_valid_r;
    out_value    = out_value_r;
    out_div_zero = out_dz_r;
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lre_pkg::BK_IDLE;
      acc_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/left_to_right_expression_eval.sv */
// ----------------------------------------------------------------------------
// left_to_right_expression_eval
// Streaming left-to-right calculator with no operator precedence.
// ----------------------------------------------------------------------------
// Characters enter one per cycle while in_ready is high: a digit extends
// the current number, any other byte closes it and queues it with its
// operator for the back end. A non-digit marked last closes two numbers,
// so in_ready stays low after it until the second, empty number is queued.
// The back end applies load, add, subtract and multiply in its idle state;
// a division occupies the bit-serial divider until its quotient is done,
// and the two-entry queue lets input continue meanwhile until it fills. One
// result per expression appears from an output register on the cycle after
// its last number is applied, held until taken while the next one proceeds.
// ----------------------------------------------------------------------------
module left_to_right_expression_eval (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_code,
  input  logic                      in_is_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lre_pkg::OUT_W-1:0] out_value,
  output logic                      out_div_zero
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  lre_pkg::q_entry_t q_entry;
  lre_pkg::q_entry_t q_head;
  lre_pkg::div_req_t div_req;
  lre_pkg::div_rsp_t div_rsp;

  lre_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  lre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  lre_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lre_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_div_zero (out_div_zero)
  );

endmodule
